// File: design/cssl_pkg.sv
`timescale 1ns / 1ps

package cssl_pkg;

	localparam logic [7:0] CH_SQUOTE    = 8'h27;
	localparam logic [7:0] CH_DQUOTE    = 8'h22;
	localparam logic [7:0] CH_BACKTICK  = 8'h60;
	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] CH_TAB       = 8'h09;
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_LF        = 8'h0A;
	localparam logic [7:0] CH_CR        = 8'h0D;
	localparam logic [7:0] CH_SLASH     = 8'h2F;
	localparam logic [7:0] CH_STAR      = 8'h2A;

	localparam logic [1:0] QUOTE_NONE     = 2'd0;
	localparam logic [1:0] QUOTE_SINGLE   = 2'd1;
	localparam logic [1:0] QUOTE_DOUBLE   = 2'd2;
	localparam logic [1:0] QUOTE_BACKTICK = 2'd3;

	localparam logic [1:0] KIND_CHAR = 2'd0;
	localparam logic [1:0] KIND_EOL  = 2'd1;
	localparam logic [1:0] KIND_ERR  = 2'd2;

	localparam int LINE_FIELD_BITS = 16;

	typedef struct packed {
		logic [7:0] ch;
		logic [7:0] next_ch;
		logic       end_of_data;
	} char_item_t;

	typedef struct packed {
		logic [1:0]                 kind;
		logic [7:0]                 out_char;
		logic [LINE_FIELD_BITS-1:0] first_line;
		logic                       has_text;
		logic                       last_of_run;
	} result_item_t;

	typedef struct packed {
		logic [1:0]                 kind;
		logic [7:0]                 out_char;
		logic [LINE_FIELD_BITS-1:0] first_line;
		logic                       has_text;
	} result_entry_t;

	function automatic logic [1:0] quote_code(input logic [7:0] c);
		logic [1:0] q;
		q = QUOTE_NONE;
		if (c == CH_SQUOTE) q = QUOTE_SINGLE;
		else if (c == CH_DQUOTE) q = QUOTE_DOUBLE;
		else if (c == CH_BACKTICK) q = QUOTE_BACKTICK;
		return q;
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
	endfunction

endpackage

// File: design/cssl_stream_if.sv
`timescale 1ns / 1ps

interface cssl_stream_if #(
	parameter type payload_t = logic [7:0]
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: design/comment_strip_line_splitter_core.sv
`timescale 1ns / 1ps

// Accepts one character transaction per clock cycle while the result buffer is free to take its
// results: the character is registered, decoded against the comment, quote and line state
// in a single step, and its zero to three results are loaded into a small result buffer that
// the output port drains one result per cycle while the receiver is ready. A character's results
// therefore occupy the output one after another, and the next character is taken in the cycle in
// which the last of them is delivered. Line numbers count in LINE_NUMBER_BITS bits and
// saturate; the low 16 bits are reported.
module comment_strip_line_splitter_core #(
	parameter int LINE_NUMBER_BITS = 16
) (
	input logic         clk,
	input logic         arst_n,
	cssl_stream_if.sink   chars,
	cssl_stream_if.source results
);
	import cssl_pkg::*;

	localparam logic [LINE_NUMBER_BITS-1:0] LINE_MAX = {LINE_NUMBER_BITS{1'b1}};
	localparam logic [LINE_NUMBER_BITS-1:0] LINE_ONE = LINE_NUMBER_BITS'(1);

	char_item_t item_s1;
	logic       valid_s1;

	logic [1:0]                  quote_q;
	logic [7:0]                  prev_q;
	logic                        line_cmt_q;
	logic                        block_cmt_q;
	logic                        skip_q;
	logic [LINE_NUMBER_BITS-1:0] counter_q;
	logic [LINE_NUMBER_BITS-1:0] start_q;
	logic                        nonempty_q;
	logic                        text_q;

	logic [1:0]                  quote_n;
	logic                        line_cmt_n;
	logic                        block_cmt_n;
	logic                        skip_n;
	logic [LINE_NUMBER_BITS-1:0] counter_n;
	logic [LINE_NUMBER_BITS-1:0] start_n;
	logic                        nonempty_n;
	logic                        text_n;

	result_entry_t res_q [3];
	logic [1:0]    res_cnt_q;
	logic [1:0]    res_idx_q;

	logic          keep_en;
	logic [7:0]    keep_char;
	logic [LINE_NUMBER_BITS-1:0] keep_line;
	logic          eol_en;
	logic [LINE_NUMBER_BITS-1:0] eol_line;
	logic          eol_text;
	logic          err_en;
	logic [LINE_NUMBER_BITS-1:0] err_line;
	logic          esc;
	logic          plain;
	logic          done;
	logic          line_end;
	logic [1:0]    q;

	result_entry_t ent_keep;
	result_entry_t ent_eol;
	result_entry_t ent_err;
	logic [1:0]    new_cnt;

	logic out_last;
	logic out_fire;
	logic buf_free;
	logic s1_fire;
	logic in_fire;

	assign out_last = res_idx_q == (res_cnt_q - 2'd1);
	assign out_fire = results.valid && results.ready;
	assign buf_free = (res_cnt_q == 2'd0) || (out_fire && out_last);
	assign s1_fire  = valid_s1 && buf_free;
	assign in_fire  = chars.valid && chars.ready;

	assign chars.ready   = !valid_s1 || s1_fire;
	assign results.valid = res_cnt_q != 2'd0;
	assign results.data  = '{
		kind:        res_q[res_idx_q].kind,
		out_char:    res_q[res_idx_q].out_char,
		first_line:  res_q[res_idx_q].first_line,
		has_text:    res_q[res_idx_q].has_text,
		last_of_run: out_last
	};

	always_comb begin
		quote_n     = quote_q;
		line_cmt_n  = line_cmt_q;
		block_cmt_n = block_cmt_q;
		skip_n      = skip_q;
		counter_n   = counter_q;
		start_n     = start_q;
		nonempty_n  = nonempty_q;
		text_n      = text_q;
		keep_en     = 1'b0;
		keep_char   = item_s1.ch;
		keep_line   = start_q;
		eol_en      = 1'b0;
		eol_line    = start_q;
		eol_text    = 1'b0;
		err_en      = 1'b0;
		err_line    = counter_q;
		esc         = prev_q == CH_BACKSLASH;
		plain       = !line_cmt_q && !block_cmt_q;
		done        = 1'b0;
		line_end    = 1'b0;
		q           = quote_code(item_s1.ch);

		if (skip_q) begin
			skip_n = 1'b0;
		end else begin
			if (plain && quote_q == QUOTE_NONE && !esc && item_s1.ch == CH_SLASH
					&& item_s1.next_ch == CH_SLASH) begin
				line_cmt_n = 1'b1;
			end else if (plain && quote_q == QUOTE_NONE && !esc && item_s1.ch == CH_SLASH
					&& item_s1.next_ch == CH_STAR) begin
				block_cmt_n = 1'b1;
				skip_n      = 1'b1;
				done        = 1'b1;
			end else if (block_cmt_q && item_s1.ch == CH_STAR && item_s1.next_ch == CH_SLASH) begin
				block_cmt_n = 1'b0;
				skip_n      = 1'b1;
				done        = 1'b1;
			end

			if (!done) begin
				if (item_s1.ch == CH_LF || item_s1.ch == CH_CR) begin
					if (item_s1.ch == CH_CR && item_s1.next_ch == CH_LF) begin
						keep_char = CH_LF;
						skip_n    = 1'b1;
					end
					if (!line_cmt_n && !block_cmt_n) keep_en = 1'b1;
					if (counter_q != LINE_MAX) counter_n = counter_q + LINE_ONE;
					if (quote_q == QUOTE_NONE && !esc) begin
						line_cmt_n = 1'b0;
						line_end   = 1'b1;
					end
				end else if (!line_cmt_n && !block_cmt_n) begin
					if (q != QUOTE_NONE && !esc) begin
						if (quote_q == q) quote_n = QUOTE_NONE;
						else if (quote_q == QUOTE_NONE) quote_n = q;
					end
					keep_en = 1'b1;
				end
			end
		end

		if (keep_en) begin
			if (!nonempty_q) begin
				start_n    = counter_q;
				nonempty_n = 1'b1;
			end
			if (!is_blank(keep_char)) text_n = 1'b1;
		end
		keep_line = start_n;

		if (line_end) begin
			eol_en     = nonempty_n;
			eol_line   = start_n;
			eol_text   = text_n;
			nonempty_n = 1'b0;
			text_n     = 1'b0;
		end

		if (item_s1.end_of_data) begin
			err_line = nonempty_n ? start_n : counter_n;
			if (nonempty_n) begin
				eol_en   = 1'b1;
				eol_line = start_n;
				eol_text = text_n;
			end
			err_en      = quote_n != QUOTE_NONE;
			quote_n     = QUOTE_NONE;
			line_cmt_n  = 1'b0;
			block_cmt_n = 1'b0;
			skip_n      = 1'b0;
			counter_n   = LINE_ONE;
			start_n     = LINE_ONE;
			nonempty_n  = 1'b0;
			text_n      = 1'b0;
		end
	end

	always_comb begin
		ent_keep = '{kind: KIND_CHAR, out_char: keep_char,
			first_line: LINE_FIELD_BITS'(keep_line), has_text: 1'b0};
		ent_eol  = '{kind: KIND_EOL, out_char: 8'd0,
			first_line: LINE_FIELD_BITS'(eol_line), has_text: eol_text};
		ent_err  = '{kind: KIND_ERR, out_char: 8'd0,
			first_line: LINE_FIELD_BITS'(err_line), has_text: 1'b0};
		new_cnt  = 2'({1'b0, keep_en} + {1'b0, eol_en} + {1'b0, err_en});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (s1_fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) item_s1 <= chars.data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quote_q     <= QUOTE_NONE;
			prev_q      <= 8'd0;
			line_cmt_q  <= 1'b0;
			block_cmt_q <= 1'b0;
			skip_q      <= 1'b0;
			counter_q   <= LINE_ONE;
			start_q     <= LINE_ONE;
			nonempty_q  <= 1'b0;
			text_q      <= 1'b0;
		end else if (s1_fire) begin
			quote_q     <= quote_n;
			prev_q      <= item_s1.end_of_data ? 8'd0 : item_s1.ch;
			line_cmt_q  <= line_cmt_n;
			block_cmt_q <= block_cmt_n;
			skip_q      <= skip_n;
			counter_q   <= counter_n;
			start_q     <= start_n;
			nonempty_q  <= nonempty_n;
			text_q      <= text_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_cnt_q <= 2'd0;
			res_idx_q <= 2'd0;
		end else if (s1_fire) begin
			res_cnt_q <= new_cnt;
			res_idx_q <= 2'd0;
		end else if (out_fire) begin
			if (out_last) begin
				res_cnt_q <= 2'd0;
				res_idx_q <= 2'd0;
			end else begin
				res_idx_q <= res_idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			if (keep_en) begin
				res_q[0] <= ent_keep;
				res_q[1] <= eol_en ? ent_eol : ent_err;
			end else begin
				res_q[0] <= eol_en ? ent_eol : ent_err;
				res_q[1] <= ent_err;
			end
			res_q[2] <= ent_err;
		end
	end

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> (res_idx_q < res_cnt_q))
		else $error("Result index points past the buffered results.");

	a_error_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.data.kind == KIND_ERR) |-> results.data.last_of_run)
		else $error("Unterminated quote error is not the last result of its character.");

	a_counter_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(counter_q != '0) && (start_q != '0))
		else $error("Line counter or line start dropped to zero.");

	a_no_load_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && !results.ready) |-> !s1_fire)
		else $error("Result buffer reloaded while a result is stalled.");

endmodule

// File: sim/tb_comment_strip_line_splitter_core.sv
`timescale 1ns / 1ps

module tb_comment_strip_line_splitter_core;
	import cssl_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 20;
	localparam int ITEM_TARGET = 160;
	localparam logic [15:0] LINE_TOP = 16'hFFFF;

	typedef struct packed {
		char_item_t   stim;
		logic [1:0]   n_fixed;
		result_item_t fixed0;
		result_item_t fixed1;
		result_item_t fixed2;
	} script_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	cssl_stream_if #(.payload_t(char_item_t))   chars_if ();
	cssl_stream_if #(.payload_t(result_item_t)) results_if ();

	comment_strip_line_splitter_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.chars(chars_if),
		.results(results_if)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	logic [1:0]  quote_state;
	logic [7:0]  last_byte;
	logic        in_line_cmt;
	logic        in_block_cmt;
	logic        skip_byte;
	logic [15:0] src_line;
	logic [15:0] logical_start;
	logic        line_open;
	logic        line_ink;

	result_item_t step_out[$];
	result_item_t typed_q[$];
	result_item_t pending_results[$];
	script_row_t  script[$];
	logic [7:0]   text_q[$];

	int  failures = 0;
	int  chars_sent = 0;
	int  results_checked = 0;
	int  kind_tally[3] = '{0, 0, 0};
	int  cycle_count = 0;
	int  src_idle_pct = 0;
	int  sink_idle_pct = 0;
	bit  long_hold = 1'b0;

	function automatic result_item_t make_result(input logic [1:0] kind, input logic [7:0] c,
		input logic [15:0] line, input logic text, input logic last);
		result_item_t r;
		r.kind = kind;
		r.out_char = c;
		r.first_line = line;
		r.has_text = text;
		r.last_of_run = last;
		return r;
	endfunction

	function automatic script_row_t make_row(input logic [7:0] c, input logic [7:0] nx,
		input logic eod, input logic [1:0] n_fixed = 2'd0, input result_item_t f0 = '0,
		input result_item_t f1 = '0, input result_item_t f2 = '0);
		script_row_t row;
		row.stim.ch = c;
		row.stim.next_ch = nx;
		row.stim.end_of_data = eod;
		row.n_fixed = n_fixed;
		row.fixed0 = f0;
		row.fixed1 = f1;
		row.fixed2 = f2;
		return row;
	endfunction

	function automatic int pick_gap();
		if ($urandom_range(0, 9) < 8) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 30);
	endfunction

	function automatic int pick_pct();
		case ($urandom_range(0, 3))
			0: return 0;
			1: return 10;
			2: return 30;
			default: return 60;
		endcase
	endfunction

	function automatic logic [7:0] any_letter();
		return 8'h61 + 8'($urandom_range(0, 25));
	endfunction

	function automatic logic [7:0] quote_byte();
		case ($urandom_range(0, 2))
			0: return CH_SQUOTE;
			1: return CH_DQUOTE;
			default: return CH_BACKTICK;
		endcase
	endfunction

	function automatic logic [7:0] pick_special();
		case ($urandom_range(0, 9))
			0: return CH_SQUOTE;
			1: return CH_DQUOTE;
			2: return CH_BACKTICK;
			3: return CH_SLASH;
			4: return CH_STAR;
			5: return CH_LF;
			6: return CH_CR;
			7: return CH_BACKSLASH;
			8: return CH_SPACE;
			default: return CH_TAB;
		endcase
	endfunction

	function automatic logic [7:0] comment_byte();
		return $urandom_range(0, 1) ? any_letter() : pick_special();
	endfunction

	task automatic clear_tracker();
		quote_state = QUOTE_NONE;
		last_byte = 8'h00;
		in_line_cmt = 1'b0;
		in_block_cmt = 1'b0;
		skip_byte = 1'b0;
		src_line = 16'd1;
		logical_start = 16'd1;
		line_open = 1'b0;
		line_ink = 1'b0;
	endtask

	task automatic keep_byte(input logic [7:0] c);
		if (!line_open) begin
			logical_start = src_line;
			line_open = 1'b1;
		end
		if (!(c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR)) begin
			line_ink = 1'b1;
		end
		step_out.push_back(make_result(KIND_CHAR, c, logical_start, 1'b0, 1'b0));
	endtask

	task automatic close_line();
		if (line_open) begin
			step_out.push_back(make_result(KIND_EOL, 8'h00, logical_start, line_ink, 1'b0));
		end
		line_open = 1'b0;
		line_ink = 1'b0;
	endtask

	// Works out the results of one character transaction and advances the tracked state.
	task automatic forecast_results(input char_item_t it);
		logic        escaped;
		logic        plain;
		logic        handled;
		logic [7:0]  kc;
		logic [1:0]  q;
		logic [15:0] err_line;
		step_out.delete();
		if (skip_byte) begin
			skip_byte = 1'b0;
		end else begin
			escaped = (last_byte == CH_BACKSLASH);
			plain = !in_line_cmt && !in_block_cmt;
			handled = 1'b0;
			if (plain && quote_state == QUOTE_NONE && !escaped && it.ch == CH_SLASH
				&& it.next_ch == CH_SLASH) begin
				in_line_cmt = 1'b1;
			end else if (plain && quote_state == QUOTE_NONE && !escaped && it.ch == CH_SLASH
				&& it.next_ch == CH_STAR) begin
				in_block_cmt = 1'b1;
				skip_byte = 1'b1;
				handled = 1'b1;
			end else if (in_block_cmt && it.ch == CH_STAR && it.next_ch == CH_SLASH) begin
				in_block_cmt = 1'b0;
				skip_byte = 1'b1;
				handled = 1'b1;
			end
			if (!handled) begin
				if (it.ch == CH_LF || it.ch == CH_CR) begin
					kc = it.ch;
					if (it.ch == CH_CR && it.next_ch == CH_LF) begin
						kc = CH_LF;
						skip_byte = 1'b1;
					end
					if (!in_line_cmt && !in_block_cmt) begin
						keep_byte(kc);
					end
					if (src_line != LINE_TOP) begin
						src_line = src_line + 16'd1;
					end
					if (quote_state == QUOTE_NONE && !escaped) begin
						in_line_cmt = 1'b0;
						close_line();
					end
				end else if (!in_line_cmt && !in_block_cmt) begin
					case (it.ch)
						CH_SQUOTE: q = QUOTE_SINGLE;
						CH_DQUOTE: q = QUOTE_DOUBLE;
						CH_BACKTICK: q = QUOTE_BACKTICK;
						default: q = QUOTE_NONE;
					endcase
					if (q != QUOTE_NONE && !escaped) begin
						if (quote_state == q) begin
							quote_state = QUOTE_NONE;
						end else if (quote_state == QUOTE_NONE) begin
							quote_state = q;
						end
					end
					keep_byte(it.ch);
				end
			end
		end
		last_byte = it.ch;
		if (it.end_of_data) begin
			err_line = line_open ? logical_start : src_line;
			close_line();
			if (quote_state != QUOTE_NONE) begin
				step_out.push_back(make_result(KIND_ERR, 8'h00, err_line, 1'b0, 1'b0));
			end
			clear_tracker();
		end
		if (step_out.size() > 0) begin
			step_out[step_out.size() - 1].last_of_run = 1'b1;
		end
	endtask

	// Offers one transaction at a falling edge and returns at the falling edge after acceptance.
	task automatic push_char(input char_item_t it);
		int gap;
		gap = ($urandom_range(0, 99) < src_idle_pct) ? pick_gap() : 0;
		if (gap > 0) begin
			chars_if.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		chars_if.data = it;
		chars_if.valid = 1'b1;
		@(posedge clk);
		while (!chars_if.ready) @(posedge clk);
		forecast_results(it);
		if (typed_q.size() > 0) begin
			foreach (typed_q[i]) pending_results.push_back(typed_q[i]);
			typed_q.delete();
		end else begin
			foreach (step_out[i]) pending_results.push_back(step_out[i]);
		end
		chars_sent++;
		@(negedge clk);
	endtask

	task automatic compose_text();
		int         ntok;
		int         r;
		logic [7:0] q;
		text_q.delete();
		ntok = $urandom_range(3, 12);
		repeat (ntok) begin
			r = $urandom_range(0, 99);
			if (r < 25) begin
				repeat ($urandom_range(1, 5)) begin
					text_q.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
						: any_letter());
				end
			end else if (r < 35) begin
				repeat ($urandom_range(1, 3)) text_q.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
			end else if (r < 50) begin
				case ($urandom_range(0, 2))
					0: text_q.push_back(CH_LF);
					1: text_q.push_back(CH_CR);
					default: begin
						text_q.push_back(CH_CR);
						text_q.push_back(CH_LF);
					end
				endcase
			end else if (r < 58) begin
				text_q.push_back(CH_SLASH);
				text_q.push_back(CH_SLASH);
				repeat ($urandom_range(0, 4)) text_q.push_back(comment_byte());
				text_q.push_back(CH_LF);
			end else if (r < 68) begin
				text_q.push_back(CH_SLASH);
				text_q.push_back(CH_STAR);
				repeat ($urandom_range(0, 6)) text_q.push_back(comment_byte());
				text_q.push_back(CH_STAR);
				text_q.push_back(CH_SLASH);
			end else if (r < 85) begin
				q = quote_byte();
				text_q.push_back(q);
				repeat ($urandom_range(0, 6)) begin
					case ($urandom_range(0, 5))
						0: begin
							text_q.push_back(CH_BACKSLASH);
							text_q.push_back(q);
						end
						1: begin
							text_q.push_back(CH_BACKSLASH);
							text_q.push_back(CH_LF);
						end
						2: begin
							text_q.push_back(CH_SLASH);
							text_q.push_back($urandom_range(0, 1) ? CH_SLASH : CH_STAR);
						end
						3: text_q.push_back(quote_byte());
						4: text_q.push_back(CH_LF);
						default: text_q.push_back(any_letter());
					endcase
				end
				if ($urandom_range(0, 7) != 0) begin
					text_q.push_back(q);
				end
			end else if (r < 93) begin
				text_q.push_back(CH_BACKSLASH);
				text_q.push_back(pick_special());
			end else begin
				text_q.push_back(8'($urandom_range(0, 255)));
			end
		end
	endtask

	task automatic send_text(input bit scrambled);
		char_item_t it;
		int         i;
		for (i = 0; i < text_q.size(); i++) begin
			it.ch = text_q[i];
			it.next_ch = (i + 1 < text_q.size()) ? text_q[i + 1] : 8'h00;
			it.end_of_data = (i == text_q.size() - 1);
			if (scrambled && $urandom_range(0, 9) == 0) begin
				it.next_ch = 8'($urandom_range(0, 255));
			end
			if (scrambled && $urandom_range(0, 19) == 0) begin
				it.end_of_data = 1'b1;
			end
			push_char(it);
		end
	endtask

	task automatic compare_field(input string fname, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			failures++;
			if (failures <= 30) begin
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
			end
		end
	endtask

	result_item_t want_res;
	result_item_t got_res;

	always @(posedge clk) begin
		if (arst_n && results_if.valid && results_if.ready) begin
			got_res = results_if.data;
			if (pending_results.size() == 0) begin
				failures++;
				if (failures <= 30) begin
					$display("%0t: unexpected result, expected none, actual kind %0d char %0h line %0d",
						$time, got_res.kind, got_res.out_char, got_res.first_line);
				end
			end else begin
				want_res = pending_results.pop_front();
				compare_field("kind", 32'(want_res.kind), 32'(got_res.kind));
				compare_field("out_char", 32'(want_res.out_char), 32'(got_res.out_char));
				compare_field("first_line", 32'(want_res.first_line), 32'(got_res.first_line));
				compare_field("has_text", 32'(want_res.has_text), 32'(got_res.has_text));
				compare_field("last_of_run", 32'(want_res.last_of_run),
					32'(got_res.last_of_run));
				results_checked++;
				kind_tally[want_res.kind]++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count = cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: run stopped after %0d cycles with %0d results outstanding", $time,
				cycle_count, pending_results.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	// The receiver's long hold-off is counted here while the sender keeps offering.
	initial begin
		int sink_wait;
		sink_wait = 0;
		results_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold) begin
				results_if.ready = 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				long_hold = 1'b0;
			end else if (sink_wait > 0) begin
				results_if.ready = 1'b0;
				sink_wait--;
			end else if ($urandom_range(0, 99) < sink_idle_pct) begin
				results_if.ready = 1'b0;
				sink_wait = pick_gap() - 1;
			end else begin
				results_if.ready = 1'b1;
			end
		end
	end

	initial begin
		char_item_t it;
		int         round;
		int         r;
		bit         hold_done;
		chars_if.valid = 1'b0;
		chars_if.data = '0;
		clear_tracker();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Comments, escapes and quotes, ending with an open double quote at end of data.
		script.push_back(make_row("a", CH_SLASH, 1'b0, 2'd1,
			make_result(KIND_CHAR, "a", 16'd1, 1'b0, 1'b1)));
		script.push_back(make_row(CH_SLASH, CH_SLASH, 1'b0));
		script.push_back(make_row(CH_SLASH, CH_DQUOTE, 1'b0));
		script.push_back(make_row(CH_DQUOTE, CH_LF, 1'b0));
		script.push_back(make_row(CH_LF, CH_BACKSLASH, 1'b0));
		script.push_back(make_row(CH_BACKSLASH, CH_LF, 1'b0));
		script.push_back(make_row(CH_LF, CH_SLASH, 1'b0));
		script.push_back(make_row(CH_SLASH, CH_STAR, 1'b0));
		script.push_back(make_row(CH_STAR, CH_SLASH, 1'b0));
		script.push_back(make_row(CH_SLASH, CH_SQUOTE, 1'b0));
		script.push_back(make_row(CH_SQUOTE, CH_STAR, 1'b0));
		script.push_back(make_row(CH_STAR, CH_SLASH, 1'b0));
		script.push_back(make_row(CH_SLASH, CH_DQUOTE, 1'b0));
		script.push_back(make_row(CH_DQUOTE, CH_BACKSLASH, 1'b0));
		script.push_back(make_row(CH_BACKSLASH, CH_DQUOTE, 1'b0));
		script.push_back(make_row(CH_DQUOTE, CH_BACKTICK, 1'b0));
		script.push_back(make_row(CH_BACKTICK, CH_LF, 1'b0));
		script.push_back(make_row(CH_LF, 8'hFF, 1'b0));
		script.push_back(make_row(8'hFF, 8'h00, 1'b1, 2'd3,
			make_result(KIND_CHAR, 8'hFF, 16'd2, 1'b0, 1'b0),
			make_result(KIND_EOL, 8'h00, 16'd2, 1'b1, 1'b0),
			make_result(KIND_ERR, 8'h00, 16'd2, 1'b0, 1'b1)));
		// A whitespace-only line closed by CR LF, then an escaped slash and a line comment.
		script.push_back(make_row(CH_SPACE, CH_TAB, 1'b0, 2'd1,
			make_result(KIND_CHAR, CH_SPACE, 16'd1, 1'b0, 1'b1)));
		script.push_back(make_row(CH_TAB, CH_CR, 1'b0));
		script.push_back(make_row(CH_CR, CH_LF, 1'b0));
		script.push_back(make_row(CH_LF, CH_BACKSLASH, 1'b0));
		script.push_back(make_row(CH_BACKSLASH, CH_SLASH, 1'b0));
		script.push_back(make_row(CH_SLASH, CH_SLASH, 1'b0));
		script.push_back(make_row(CH_SLASH, 8'h00, 1'b1));
		// A zero byte, then a backtick left open at end of data.
		script.push_back(make_row(8'h00, CH_BACKTICK, 1'b0, 2'd1,
			make_result(KIND_CHAR, 8'h00, 16'd1, 1'b0, 1'b1)));
		script.push_back(make_row(CH_BACKTICK, 8'h00, 1'b1));

		src_idle_pct = 20;
		sink_idle_pct = 20;
		foreach (script[i]) begin
			typed_q.delete();
			if (script[i].n_fixed >= 2'd1) typed_q.push_back(script[i].fixed0);
			if (script[i].n_fixed >= 2'd2) typed_q.push_back(script[i].fixed1);
			if (script[i].n_fixed >= 2'd3) typed_q.push_back(script[i].fixed2);
			push_char(script[i].stim);
		end

		round = 0;
		hold_done = 1'b0;
		while (chars_sent < ITEM_TARGET || !hold_done) begin
			src_idle_pct = pick_pct();
			sink_idle_pct = pick_pct();
			if (!hold_done && round >= 2) begin
				src_idle_pct = 0;
				long_hold = 1'b1;
				hold_done = 1'b1;
			end
			round++;
			r = $urandom_range(0, 9);
			if (r < 7) begin
				compose_text();
				send_text(1'b0);
			end else if (r < 9) begin
				compose_text();
				send_text(1'b1);
			end else begin
				repeat ($urandom_range(3, 10)) begin
					it.ch = 8'($urandom_range(0, 255));
					it.next_ch = 8'($urandom_range(0, 255));
					it.end_of_data = ($urandom_range(0, 7) == 0);
					push_char(it);
				end
			end
		end

		chars_if.valid = 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d character transactions: directed rows, generated texts and raw bytes.",
			chars_sent);
		$display("Checked %0d results: %0d kept, %0d line ends, %0d open-quote errors.",
			results_checked, kind_tally[KIND_CHAR], kind_tally[KIND_EOL], kind_tally[KIND_ERR]);
		if (failures == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
